// ----- design/pcm_record_deframer_unit_defines.svh -----
// Assertion macros used by the record deframer top level.
`ifndef PCM_RECORD_DEFRAMER_UNIT_DEFINES_SVH
`define PCM_RECORD_DEFRAMER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define PCMRD_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("deframer check failed");

// Next-cycle implication, sampled on clk and disabled during reset.
`define PCMRD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("deframer sequence check failed");

`endif

// ----- design/pcmrd_pkg.sv -----
// Package with constants, codes and types of the record deframer.
`default_nettype none
package pcmrd_pkg;

  localparam int HdrLen     = 48;
  localparam int MaxSamples = 2048;
  localparam int CntW       = 16;
  localparam int PosW       = 13;
  localparam int PayloadW   = 13;
  localparam int IdxW       = 11;
  localparam int CfgIdxW    = 3;
  localparam int CfgDataW   = 32;
  localparam int QPtrW      = 2;
  localparam int QDepth     = 1 << QPtrW;

  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_SAMPLE = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ERR_OK       = 2'd0,
    ERR_FRAMING  = 2'd1,
    ERR_METADATA = 2'd2
  } err_t;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MAGIC     = 3'd0,
    CFG_VERSION   = 3'd1,
    CFG_HDR_BYTES = 3'd2,
    CFG_PAYLOAD   = 3'd3,
    CFG_FRAMES    = 3'd4,
    CFG_FLAG_MASK = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    kind_t          kind;
    err_t           err;
    logic [31:0]    gen;
    logic [31:0]    flags;
    logic [63:0]    first_pos;
    logic [63:0]    tstamp;
    logic [31:0]    frames;
    logic [15:0]    sval;
    logic [IdxW-1:0] sidx;
    logic           last;
  } res_t;

  typedef struct packed {
    logic           full;
    logic           empty;
    logic [QPtrW:0] count;
  } q_stat_t;

endpackage
`default_nettype wire

// ----- design/pcmrd_ifs.sv -----
// Valid/ready channel interfaces for record bytes and deframed words.
`default_nettype none
interface pcmrd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       record_start;

  modport source (output valid, output data_byte, output record_start, input ready);
  modport sink (input valid, input data_byte, input record_start, output ready);
endinterface

interface pcmrd_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         item_kind;
  logic [1:0]         error_code;
  logic [31:0]        stream_gen;
  logic [31:0]        flag_bits;
  logic [63:0]        first_position;
  logic [63:0]        timestamp_ns;
  logic [31:0]        frames_in_record;
  logic signed [15:0] sample_value;
  logic [10:0]        sample_index;
  logic               last_sample;

  modport source (output valid, output item_kind, output error_code, output stream_gen,
                  output flag_bits, output first_position, output timestamp_ns,
                  output frames_in_record, output sample_value, output sample_index,
                  output last_sample, input ready);
  modport sink (input valid, input item_kind, input error_code, input stream_gen,
                input flag_bits, input first_position, input timestamp_ns,
                input frames_in_record, input sample_value, input sample_index,
                input last_sample, output ready);
endinterface
`default_nettype wire

// ----- design/pcmrd_front.sv -----
// Front end: configuration, byte tracking, header assembly and checks.
`default_nettype none
module pcmrd_front (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  pcmrd_in_if.sink                           in_ch,
  input  wire logic                          cfg_we,
  input  wire logic [pcmrd_pkg::CfgIdxW-1:0] cfg_index,
  input  wire logic [pcmrd_pkg::CfgDataW-1:0] cfg_wdata,
  input  wire logic                          q_full,
  output logic                               q_push,
  output pcmrd_pkg::res_t                    q_entry
);
  import pcmrd_pkg::*;

  logic [31:0]         magic_r;
  logic [15:0]         version_r;
  logic [7:0]          hdr_bytes_r;
  logic [PayloadW-1:0] payload_r;
  logic [31:0]         frames_r;
  logic [31:0]         flag_mask_r;

  logic [PosW-1:0] pos_r, pos_nxt;
  logic [63:0]     hdr_r [6];
  logic [63:0]     hdr_nxt [6];
  logic            accepted_r, accepted_nxt;
  logic            done_r, done_nxt;
  logic [7:0]      low_byte_r, low_byte_nxt;

  logic            accept;
  logic            st;
  logic [PosW-1:0] pos_e;
  logic            acc_e;
  logic            done_e;
  logic [2:0]      widx;
  logic [63:0]     w5_new;
  logic            framing_bad;
  logic            meta_bad;
  logic [CntW-1:0] half_payload;
  logic [CntW-1:0] scount;
  logic [PosW-1:0] first;
  logic [PosW-1:0] rel;
  logic [CntW-1:0] idx;
  logic            last_s;
  kind_t           kind;
  err_t            err;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign st          = in_ch.record_start;

  assign pos_e  = st ? '0 : pos_r;
  assign acc_e  = st ? 1'b0 : accepted_r;
  assign done_e = st ? 1'b0 : done_r;
  assign widx   = pos_e[5:3];
  assign w5_new = {hdr_r[5][55:0], in_ch.data_byte};

  assign framing_bad = (hdr_r[0][63:32] != magic_r) || (hdr_r[0][31:16] != version_r) ||
                       (hdr_r[0][15:0] != {8'd0, hdr_bytes_r}) ||
                       (hdr_r[4][31:0] != {{(32-PayloadW){1'b0}}, payload_r}) ||
                       (w5_new != 64'd0);
  assign meta_bad    = (hdr_r[1][63:32] == 32'd0) || (hdr_r[4][63:32] != frames_r) ||
                       ((hdr_r[1][31:0] & ~flag_mask_r) != 32'd0);

  assign half_payload = CntW'(payload_r[PayloadW-1:1]);
  assign scount = (half_payload > CntW'(MaxSamples)) ? CntW'(MaxSamples) : half_payload;
  assign first  = (hdr_bytes_r < 8'(HdrLen)) ? PosW'(HdrLen) : PosW'(hdr_bytes_r);
  assign rel    = pos_e - first;
  assign idx    = CntW'(rel[PosW-1:1]);
  assign last_s = (idx + CntW'(1)) >= scount;

  always_comb begin
    pos_nxt      = pos_r;
    accepted_nxt = accepted_r;
    done_nxt     = done_r;
    low_byte_nxt = low_byte_r;
    for (int w = 0; w < 6; w++) begin
      hdr_nxt[w] = hdr_r[w];
    end
    q_push = 1'b0;
    kind   = KIND_HEADER;
    err    = ERR_OK;
    if (accept) begin
      if (st) begin
        pos_nxt      = '0;
        accepted_nxt = 1'b0;
        done_nxt     = 1'b0;
        low_byte_nxt = 8'd0;
        for (int w = 0; w < 6; w++) begin
          hdr_nxt[w] = 64'd0;
        end
      end
      if (!done_e) begin
        pos_nxt = pos_e + PosW'(1);
        if (pos_e < PosW'(HdrLen)) begin
          hdr_nxt[widx] = {hdr_nxt[widx][55:0], in_ch.data_byte};
          if (pos_e == PosW'(HdrLen - 1)) begin
            q_push = 1'b1;
            if (framing_bad) begin
              kind     = KIND_ERROR;
              err      = ERR_FRAMING;
              done_nxt = 1'b1;
            end else if (meta_bad) begin
              kind     = KIND_ERROR;
              err      = ERR_METADATA;
              done_nxt = 1'b1;
            end else begin
              accepted_nxt = 1'b1;
              done_nxt     = (scount == '0);
            end
          end
        end else if (!acc_e) begin
          done_nxt = 1'b1;
        end else if (pos_e >= first) begin
          if (!rel[0]) begin
            low_byte_nxt = in_ch.data_byte;
          end else begin
            q_push = 1'b1;
            kind   = KIND_SAMPLE;
            if (last_s) begin
              done_nxt = 1'b1;
            end
          end
        end
      end
    end
  end

  always_comb begin
    q_entry           = '0;
    q_entry.kind      = kind;
    q_entry.err       = err;
    q_entry.gen       = hdr_r[1][63:32];
    q_entry.flags     = hdr_r[1][31:0];
    q_entry.first_pos = hdr_r[2];
    q_entry.tstamp    = hdr_r[3];
    q_entry.frames    = hdr_r[4][63:32];
    q_entry.sval      = {in_ch.data_byte, low_byte_r};
    q_entry.sidx      = idx[IdxW-1:0];
    q_entry.last      = last_s;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      magic_r     <= 32'd0;
      version_r   <= 16'd0;
      hdr_bytes_r <= 8'(HdrLen);
      payload_r   <= '0;
      frames_r    <= 32'd0;
      flag_mask_r <= 32'd0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_MAGIC:     magic_r     <= cfg_wdata;
        CFG_VERSION:   version_r   <= cfg_wdata[15:0];
        CFG_HDR_BYTES: hdr_bytes_r <= cfg_wdata[7:0];
        CFG_PAYLOAD:   payload_r   <= cfg_wdata[PayloadW-1:0];
        CFG_FRAMES:    frames_r    <= cfg_wdata;
        CFG_FLAG_MASK: flag_mask_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= '0;
      accepted_r <= 1'b0;
      done_r     <= 1'b1;
    end else begin
      pos_r      <= pos_nxt;
      accepted_r <= accepted_nxt;
      done_r     <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    low_byte_r <= low_byte_nxt;
    for (int w = 0; w < 6; w++) begin
      hdr_r[w] <= hdr_nxt[w];
    end
  end

endmodule
`default_nettype wire

// ----- design/pcmrd_queue.sv -----
// Short register queue between the front end and the output stage.
`default_nettype none
module pcmrd_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire pcmrd_pkg::res_t wr_entry,
  input  wire logic            pop,
  output pcmrd_pkg::res_t      rd_entry,
  output pcmrd_pkg::q_stat_t   stat
);
  import pcmrd_pkg::*;

  res_t             mem_r [QDepth];
  logic [QPtrW-1:0] wr_ptr_r;
  logic [QPtrW-1:0] rd_ptr_r;
  logic [QPtrW:0]   count_r;

  assign rd_entry   = mem_r[rd_ptr_r];
  assign stat.full  = (count_r == (QPtrW + 1)'(QDepth));
  assign stat.empty = (count_r == '0);
  assign stat.count = count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPtrW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QPtrW'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + (QPtrW + 1)'(1);
      end else if (pop && !push) begin
        count_r <= count_r - (QPtrW + 1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_entry;
    end
  end

endmodule
`default_nettype wire

// ----- design/pcmrd_back.sv -----
// Output stage: formats each queued word by kind and holds it for the sink.
`default_nettype none
module pcmrd_back (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire pcmrd_pkg::res_t    head,
  input  wire pcmrd_pkg::q_stat_t stat,
  output logic                    pop,
  pcmrd_out_if.source             out_ch
);
  import pcmrd_pkg::*;

  logic out_valid_r;
  res_t res_r, res_nxt;

  assign pop = !stat.empty && (!out_valid_r || out_ch.ready);

  always_comb begin
    res_nxt = head;
    if (head.kind != KIND_HEADER) begin
      res_nxt.gen       = 32'd0;
      res_nxt.flags     = 32'd0;
      res_nxt.first_pos = 64'd0;
      res_nxt.tstamp    = 64'd0;
      res_nxt.frames    = 32'd0;
    end
    if (head.kind != KIND_SAMPLE) begin
      res_nxt.sval = 16'd0;
      res_nxt.sidx = '0;
      res_nxt.last = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.item_kind        = res_r.kind;
  assign out_ch.error_code       = res_r.err;
  assign out_ch.stream_gen       = res_r.gen;
  assign out_ch.flag_bits        = res_r.flags;
  assign out_ch.first_position   = res_r.first_pos;
  assign out_ch.timestamp_ns     = res_r.tstamp;
  assign out_ch.frames_in_record = res_r.frames;
  assign out_ch.sample_value     = $signed(res_r.sval);
  assign out_ch.sample_index     = res_r.sidx;
  assign out_ch.last_sample      = res_r.last;

endmodule
`default_nettype wire

// ----- design/pcm_record_deframer_unit.sv -----
// Top level of the PCM record deframer: front end, word queue and output stage.
// A word caused by a byte is written into the queue and then into the output register.
// Throughput: one byte per cycle; the four-entry queue and output register absorb sink stalls.
// The input stalls only when the queue is full, i.e. when the sink has held off for a while.
// Reset (synchronous, active low) clears the queue and output, loads configuration defaults
// and leaves the block waiting for a byte that carries the record start mark.
`default_nettype none
`include "pcm_record_deframer_unit_defines.svh"
module pcm_record_deframer_unit (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  pcmrd_in_if.sink                            in_ch,
  pcmrd_out_if.source                         out_ch,
  input  wire logic                           cfg_we,
  input  wire logic [pcmrd_pkg::CfgIdxW-1:0]  cfg_index,
  input  wire logic [pcmrd_pkg::CfgDataW-1:0] cfg_wdata
);
  import pcmrd_pkg::*;

  logic    q_push;
  logic    q_pop;
  res_t    q_wr_entry;
  res_t    q_rd_entry;
  q_stat_t q_stat;
  logic    out_err;

  pcmrd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .q_full    (q_stat.full),
    .q_push    (q_push),
    .q_entry   (q_wr_entry)
  );

  pcmrd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .wr_entry (q_wr_entry),
    .pop      (q_pop),
    .rd_entry (q_rd_entry),
    .stat     (q_stat)
  );

  pcmrd_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (q_rd_entry),
    .stat   (q_stat),
    .pop    (q_pop),
    .out_ch (out_ch)
  );

  assign out_err = out_ch.valid && (out_ch.item_kind == KIND_ERROR);

  `PCMRD_ASSERT_IMPL(a_no_overflow, q_push, !q_stat.full)
  `PCMRD_ASSERT_IMPL(a_no_underflow, q_pop, !q_stat.empty)
  `PCMRD_ASSERT_NEXT(a_count_up, q_push && !q_pop, q_stat.count == $past(q_stat.count) + 1'b1)
  `PCMRD_ASSERT_IMPL(a_error_coded, out_err, out_ch.error_code != ERR_OK)

endmodule
`default_nettype wire

// ----- tb/tb_pcm_record_deframer_unit.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the PCM record deframer with a built-in byte-level predictor.
module tb_pcm_record_deframer_unit;
  import pcmrd_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int POST_DRAIN_CYCLES = 8;
  localparam int MAX_PRINTED = 50;
  localparam logic [CfgIdxW-1:0] CFG_SPARE_A = 3'd6;
  localparam logic [CfgIdxW-1:0] CFG_SPARE_B = 3'd7;

  typedef struct packed {
    logic [7:0] data;
    logic       start;
  } byte_item_t;

  typedef struct packed {
    logic [31:0] magic;
    logic [15:0] version;
    logic [15:0] hsz;
    logic [31:0] gen;
    logic [31:0] flags;
    logic [63:0] fpos;
    logic [63:0] tstamp;
    logic [31:0] frames;
    logic [31:0] payload;
    logic [63:0] reserved;
  } rec_hdr_t;

  typedef struct packed {
    logic [31:0]         magic;
    logic [15:0]         version;
    logic [7:0]          hdr;
    logic [PayloadW-1:0] payload;
    logic [31:0]         frames;
    logic [31:0]         mask;
  } cfg_set_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CfgIdxW-1:0] cfg_index;
  logic [CfgDataW-1:0] cfg_wdata;

  pcmrd_in_if in_ch();
  pcmrd_out_if out_ch();

  pcm_record_deframer_unit uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  byte_item_t pending_bytes[$];
  res_t expected_words[$];
  int mismatch_count = 0;
  int cycle_count = 0;
  int in_idle_pct = 22;
  int out_idle_pct = 22;
  int random_bytes = 0;

  cfg_set_t active_cfg;
  int rec_pos = 0;
  logic [63:0] hdr_shift [6];
  bit rec_accepted = 1'b0;
  bit rec_done = 1'b1;
  logic [7:0] low_byte = 8'h00;

  function automatic int sample_total();
    int n;
    n = int'(active_cfg.payload) >> 1;
    return (n > MaxSamples) ? MaxSamples : n;
  endfunction

  function automatic int body_len();
    int gap;
    gap = (int'(active_cfg.hdr) > HdrLen) ? int'(active_cfg.hdr) - HdrLen : 0;
    return gap + 2 * sample_total();
  endfunction

  // Advances the record state by one byte and returns 1 when that byte yields a word.
  function automatic bit deframe_byte(input logic [7:0] b, input logic start, output res_t r);
    int p, first, rel, idx;
    logic [31:0] mg, gen, flg, fc, ps;
    logic [15:0] ver, hsz;
    bit last_one;
    r = '0;
    if (start) begin
      rec_pos = 0;
      for (int k = 0; k < 6; k++) hdr_shift[k] = '0;
      rec_accepted = 1'b0;
      rec_done = 1'b0;
      low_byte = 8'h00;
    end
    if (rec_done) return 1'b0;
    p = rec_pos;
    rec_pos = p + 1;
    if (p < HdrLen) begin
      hdr_shift[p >> 3] = {hdr_shift[p >> 3][55:0], b};
      if (p != HdrLen - 1) return 1'b0;
      mg = hdr_shift[0][63:32];
      ver = hdr_shift[0][31:16];
      hsz = hdr_shift[0][15:0];
      gen = hdr_shift[1][63:32];
      flg = hdr_shift[1][31:0];
      fc = hdr_shift[4][63:32];
      ps = hdr_shift[4][31:0];
      if (mg != active_cfg.magic || ver != active_cfg.version ||
          hsz != {8'h00, active_cfg.hdr} || ps != {19'h0, active_cfg.payload} ||
          hdr_shift[5] != 64'h0) begin
        r.kind = KIND_ERROR;
        r.err = ERR_FRAMING;
        rec_done = 1'b1;
        return 1'b1;
      end
      if (gen == 32'h0 || fc != active_cfg.frames || (flg & ~active_cfg.mask) != 32'h0) begin
        r.kind = KIND_ERROR;
        r.err = ERR_METADATA;
        rec_done = 1'b1;
        return 1'b1;
      end
      r.kind = KIND_HEADER;
      r.err = ERR_OK;
      r.gen = gen;
      r.flags = flg;
      r.first_pos = hdr_shift[2];
      r.tstamp = hdr_shift[3];
      r.frames = fc;
      rec_accepted = 1'b1;
      if (sample_total() == 0) rec_done = 1'b1;
      return 1'b1;
    end
    if (!rec_accepted) begin
      rec_done = 1'b1;
      return 1'b0;
    end
    first = (int'(active_cfg.hdr) < HdrLen) ? HdrLen : int'(active_cfg.hdr);
    if (p < first) return 1'b0;
    rel = p - first;
    if (rel % 2 == 0) begin
      low_byte = b;
      return 1'b0;
    end
    idx = rel >> 1;
    last_one = (idx + 1) >= sample_total();
    if (last_one) rec_done = 1'b1;
    r.kind = KIND_SAMPLE;
    r.err = ERR_OK;
    r.sval = {b, low_byte};
    r.sidx = IdxW'(idx);
    r.last = last_one;
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTED) $display("[%0t] ERROR: %s", $time, what);
  endtask

  task automatic check_field(input string name, input logic [63:0] got, input logic [63:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  always @(posedge clk) begin : drive_bytes
    byte_item_t next_item;
    res_t predicted;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.data_byte <= 8'h00;
      in_ch.record_start <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        if (deframe_byte(in_ch.data_byte, in_ch.record_start, predicted))
          expected_words.push_back(predicted);
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_bytes.size() > 0 && $urandom_range(99) >= in_idle_pct) begin
          next_item = pending_bytes.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.data_byte <= next_item.data;
          in_ch.record_start <= next_item.start;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : watch_words
    res_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_words.size() == 0) begin
        report_mismatch($sformatf("unexpected word of kind %0d", out_ch.item_kind));
      end else begin
        want = expected_words.pop_front();
        check_field("item_kind", 64'(out_ch.item_kind), 64'(want.kind));
        check_field("error_code", 64'(out_ch.error_code), 64'(want.err));
        check_field("stream_gen", 64'(out_ch.stream_gen), 64'(want.gen));
        check_field("flag_bits", 64'(out_ch.flag_bits), 64'(want.flags));
        check_field("first_position", out_ch.first_position, want.first_pos);
        check_field("timestamp_ns", out_ch.timestamp_ns, want.tstamp);
        check_field("frames_in_record", 64'(out_ch.frames_in_record), 64'(want.frames));
        check_field("sample_value", 64'($unsigned(out_ch.sample_value)), 64'(want.sval));
        check_field("sample_index", 64'(out_ch.sample_index), 64'(want.sidx));
        check_field("last_sample", 64'(out_ch.last_sample), 64'(want.last));
      end
    end
    out_ch.ready <= ($urandom_range(99) >= out_idle_pct);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic void push_byte(input logic [7:0] b, input logic start);
    byte_item_t item;
    item.data = b;
    item.start = start;
    pending_bytes.push_back(item);
  endfunction

  function automatic void queue_header(input rec_hdr_t h);
    logic [383:0] bits;
    bits = h;
    for (int i = 0; i < HdrLen; i++) push_byte(bits[383 - 8 * i -: 8], i == 0);
  endfunction

  function automatic void queue_junk(input int n);
    repeat (n) push_byte(8'($urandom_range(255)), 1'b0);
  endfunction

  function automatic rec_hdr_t good_header();
    rec_hdr_t h;
    h.magic = active_cfg.magic;
    h.version = active_cfg.version;
    h.hsz = {8'h00, active_cfg.hdr};
    h.gen = $urandom;
    if (h.gen == 32'h0) h.gen = 32'h1;
    h.flags = $urandom & active_cfg.mask;
    h.fpos = {$urandom, $urandom};
    h.tstamp = {$urandom, $urandom};
    h.frames = active_cfg.frames;
    h.payload = {19'h0, active_cfg.payload};
    h.reserved = 64'h0;
    return h;
  endfunction

  function automatic cfg_set_t random_settings();
    cfg_set_t s;
    s.magic = $urandom;
    s.version = 16'($urandom_range(65535));
    case ($urandom_range(9))
      0: s.hdr = 8'($urandom_range(47));
      1: s.hdr = 8'd255;
      2: s.hdr = 8'($urandom_range(80, 57));
      default: s.hdr = 8'($urandom_range(56, 48));
    endcase
    case ($urandom_range(9))
      0: s.payload = '0;
      1, 2: s.payload = PayloadW'($urandom_range(64, 25));
      default: s.payload = PayloadW'($urandom_range(24, 1));
    endcase
    s.frames = ($urandom_range(3) == 0) ? 32'h0 : $urandom;
    case ($urandom_range(5))
      0: s.mask = 32'h0;
      1: s.mask = '1;
      default: s.mask = $urandom;
    endcase
    return s;
  endfunction

  function automatic void queue_random_record();
    rec_hdr_t h;
    int body, r, k, stray_at;
    h = good_header();
    body = body_len();
    r = $urandom_range(99);
    if (r >= 55) begin
      if (r < 60) h.magic ^= 32'h1 << $urandom_range(31);
      else if (r < 63) h.version ^= 16'h1 << $urandom_range(15);
      else if (r < 67) h.hsz ^= 16'h1 << $urandom_range(15);
      else if (r < 71) h.payload ^= 32'h1 << $urandom_range(31);
      else if (r < 74) h.reserved ^= 64'h1 << $urandom_range(63);
      else if (r < 78) h.gen = 32'h0;
      else if (r < 82) h.frames ^= 32'h1 << $urandom_range(31);
      else if (r < 87 && active_cfg.mask != '1) begin
        do k = $urandom_range(31); while (active_cfg.mask[k]);
        h.flags[k] = 1'b1;
      end
    end
    if ($urandom_range(99) < 12 && body > 0) body = $urandom_range(body - 1);
    stray_at = ($urandom_range(99) < 4 && body > 0) ? $urandom_range(body - 1) : -1;
    if ($urandom_range(99) < 5) queue_junk($urandom_range(4, 1));
    queue_header(h);
    for (int i = 0; i < body; i++) push_byte(8'($urandom_range(255)), i == stray_at);
    if ($urandom_range(99) < 15) queue_junk($urandom_range(5, 1));
    random_bytes += HdrLen + body;
  endfunction

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_MAGIC: active_cfg.magic = val;
      CFG_VERSION: active_cfg.version = val[15:0];
      CFG_HDR_BYTES: active_cfg.hdr = val[7:0];
      CFG_PAYLOAD: active_cfg.payload = val[PayloadW-1:0];
      CFG_FRAMES: active_cfg.frames = val;
      CFG_FLAG_MASK: active_cfg.mask = val;
      default: ;
    endcase
  endtask

  task automatic apply_settings(input cfg_set_t s);
    write_reg(CFG_MAGIC, s.magic);
    write_reg(CFG_VERSION, {16'($urandom), s.version});
    write_reg(CFG_HDR_BYTES, {24'($urandom), s.hdr});
    write_reg(CFG_PAYLOAD, {19'($urandom), s.payload});
    write_reg(CFG_FRAMES, s.frames);
    write_reg(CFG_FLAG_MASK, s.mask);
    write_reg($urandom_range(1) ? CFG_SPARE_A : CFG_SPARE_B, $urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (pending_bytes.size() != 0 || in_ch.valid || expected_words.size() != 0);
    repeat (POST_DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin : run_test
    rec_hdr_t h;
    cfg_set_t s;
    int phase, target;
    cfg_we = 1'b0;
    cfg_index = CFG_MAGIC;
    cfg_wdata = '0;
    rst_n = 1'b0;
    active_cfg = '{magic: 32'h0, version: 16'h0, hdr: 8'd48, payload: '0,
                   frames: 32'h0, mask: 32'h0};
    for (int k = 0; k < 6; k++) hdr_shift[k] = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset configuration: stray bytes, an empty record and a zero generation.
    queue_junk(3);
    queue_header(good_header());
    queue_junk(2);
    h = good_header();
    h.gen = 32'h0;
    queue_header(h);
    wait_idle();

    s = '{magic: '1, version: '1, hdr: 8'd50, payload: PayloadW'(7), frames: '1, mask: '1};
    apply_settings(s);
    h = good_header();
    h.gen = '1;
    h.flags = '1;
    h.fpos = '1;
    h.tstamp = '1;
    queue_header(h);
    push_byte(8'hA5, 1'b0);
    push_byte(8'h5A, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h7F, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h55, 1'b0);
    queue_header(good_header());
    queue_junk(3);
    queue_header(good_header());
    queue_junk(2);
    push_byte(8'h01, 1'b0);
    push_byte(8'h02, 1'b0);
    wait_idle();
    @(negedge clk);
    push_byte(8'h03, 1'b0);
    push_byte(8'h04, 1'b0);
    push_byte(8'h05, 1'b0);
    push_byte(8'h06, 1'b0);
    h = good_header();
    h.hsz = 16'h0132;
    queue_header(h);
    queue_junk(4);
    h = good_header();
    h.payload = 32'h0001_0007;
    queue_header(h);
    h = good_header();
    h.reserved = 64'h8000_0000_0000_0000;
    queue_header(h);
    h = good_header();
    h.magic = 32'h0;
    queue_header(h);
    h = good_header();
    h.version = 16'h7FFF;
    queue_header(h);
    h = good_header();
    h.gen = 32'h0;
    queue_header(h);
    h = good_header();
    h.frames = 32'hFFFF_FFFE;
    queue_header(h);
    queue_junk(2);
    wait_idle();

    s = '{magic: 32'h0, version: 16'h0, hdr: 8'd0, payload: PayloadW'(4), frames: 32'h0,
          mask: 32'h0000_00A5};
    apply_settings(s);
    h = good_header();
    h.flags = 32'h0000_00A5;
    queue_header(h);
    queue_junk(5);
    h = good_header();
    h.flags = 32'h0000_0100;
    queue_header(h);
    queue_junk(4);
    wait_idle();

    // The largest payload register value runs into the per-record sample limit.
    s = '{magic: $urandom, version: 16'($urandom), hdr: 8'd255, payload: '1,
          frames: $urandom, mask: 32'h0};
    apply_settings(s);
    queue_header(good_header());
    queue_junk(body_len() + 1);
    wait_idle();

    phase = 0;
    while (random_bytes < 1600) begin
      if (phase == 1) begin
        in_idle_pct = 0;
        out_idle_pct = 0;
      end else begin
        in_idle_pct = 22;
        out_idle_pct = 22;
      end
      apply_settings(random_settings());
      target = random_bytes + ((phase == 1) ? 400 : 220);
      while (random_bytes < target) queue_random_record();
      wait_idle();
      phase++;
    end

    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule

// ----- sim.f -----
+incdir+design
design/pcmrd_pkg.sv
design/pcmrd_ifs.sv
design/pcmrd_front.sv
design/pcmrd_queue.sv
design/pcmrd_back.sv
design/pcm_record_deframer_unit.sv
tb/tb_pcm_record_deframer_unit.sv
